@@ src/lebs_pkg.sv @@
// Shared types, constants and helpers for the LED effect button sequencer.
// No dependencies; imported by lebs_debounce and led_effect_button_sequencer.
package lebs_pkg;

  localparam int unsigned DEB_W   = 16;
  localparam int unsigned PHASE_W = 11;
  localparam int unsigned LED_N   = 6;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned OUT_W   = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_PER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_ON  = 2'd2;

  // Reset values
  localparam logic [DEB_W-1:0]   DEBOUNCE_RST  = 16'd20;
  localparam logic [PHASE_W-1:0] BLINK_PER_RST = 11'd1000;
  localparam logic [PHASE_W-1:0] BLINK_ON_RST  = 11'd500;

  // Effect codes
  localparam logic [MODE_W-1:0] MODE_BLINK = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CHASE = 2'd2;

  localparam logic [PHASE_W-1:0] CHASE_PERIOD = 11'd1800;
  localparam logic [PHASE_W-1:0] CHASE_EDGE1  = 11'd300;
  localparam logic [PHASE_W-1:0] CHASE_EDGE2  = 11'd600;
  localparam logic [PHASE_W-1:0] CHASE_EDGE3  = 11'd900;
  localparam logic [PHASE_W-1:0] CHASE_EDGE4  = 11'd1200;
  localparam logic [PHASE_W-1:0] CHASE_EDGE5  = 11'd1600;
  localparam logic [LED_N-1:0]   ALL_LEDS     = 6'h3F;

  typedef struct packed {
    logic change; // an accepted level change this tick
    logic level;  // new accepted level
  } lebs_event_t;

  // Index of the chase window that holds a phase, 0 to 5
  function automatic logic [2:0] chase_window(input logic [PHASE_W-1:0] phase);
    logic [2:0] w;
    if (phase < CHASE_EDGE1)      w = 3'd0;
    else if (phase < CHASE_EDGE2) w = 3'd1;
    else if (phase < CHASE_EDGE3) w = 3'd2;
    else if (phase < CHASE_EDGE4) w = 3'd3;
    else if (phase < CHASE_EDGE5) w = 3'd4;
    else                          w = 3'd5;
    return w;
  endfunction

endpackage

@@ src/lebs_debounce.sv @@
// Button debounce: tracks the accepted level and ticks since the last change.
// Depends on lebs_pkg.
module lebs_debounce (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         advance,
  input  logic                         level,
  input  logic [lebs_pkg::DEB_W-1:0]   debounce_ticks,
  output lebs_pkg::lebs_event_t        evt
);
  import lebs_pkg::*;

  logic             accepted_level;
  logic [DEB_W-1:0] since_change;
  logic [DEB_W-1:0] since_inc;

  // saturate at the top count
  assign since_inc = (since_change == {DEB_W{1'b1}}) ? since_change : since_change + 1'b1;

  assign evt.change = (level != accepted_level) && (since_inc >= debounce_ticks);
  assign evt.level  = level;

  always_ff @(posedge clk) begin
    if (rst) begin
      accepted_level <= 1'b0;
      since_change   <= '0;
    end else if (advance) begin
      if (evt.change) begin
        accepted_level <= level;
        since_change   <= '0;
      end else begin
        since_change   <= since_inc;
      end
    end
  end

endmodule

@@ src/led_effect_button_sequencer.sv @@
// LED effect sequencer driven by a debounced push button.
// Depends on lebs_pkg and lebs_debounce.
//
// Usage:
//   Slave channel (s_tvalid/s_tready/s_tdata) takes one beat per millisecond
//   tick; s_tdata[0] is the sampled button level (1 = pressed).
//   Master channel (m_tvalid/m_tready/m_tdata) returns exactly one beat per
//   tick: LED levels, indicator and active effect after that tick.
//   Configuration: cfg_we writes cfg_data to register cfg_index
//   (0 debounce ticks, 1 blink period, 2 blink on ticks); other indexes are
//   dropped. Write only while no tick is in flight.
// Timing:
//   The result beat is registered and appears in the cycle after its tick;
//   a tick can be taken every cycle unless stalled. All state advances in
//   one pass of short counter and compare logic into the output register.
// Reset (rst, synchronous): blink effect, LEDs off, indicator low, counters
//   cleared, registers back to 20 / 1000 / 500, no result pending.
// Stall: while m_tready is low and a result is held, s_tready drops; the
//   held beat and all state stay put until the result is taken.
module led_effect_button_sequencer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,   // [0] button_level
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [lebs_pkg::OUT_W-1:0]        m_tdata,   // [5:0] led_bits, [6] button_led,
                                                       // [8:7] effect_mode
  input  logic                              cfg_we,
  input  logic [lebs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lebs_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import lebs_pkg::*;

  logic [DEB_W-1:0]   debounce_ticks;
  logic [PHASE_W-1:0] blink_period;
  logic [PHASE_W-1:0] blink_on_ticks;

  logic               mode_is_chase;
  logic               mode_is_chase_next;
  logic [PHASE_W-1:0] phase_count;
  logic [PHASE_W-1:0] phase_next;
  logic [PHASE_W-1:0] phase_inc;
  logic [PHASE_W-1:0] period;
  logic [LED_N-1:0]   led_store;
  logic [LED_N-1:0]   led_next;
  logic [LED_N-1:0]   led_base;
  logic               indicator;
  logic               indicator_next;
  logic [2:0]         win;
  logic [2:0]         win_prev;
  logic               accept;
  lebs_event_t        evt;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  lebs_debounce u_debounce (
    .clk            (clk),
    .rst            (rst),
    .advance        (accept),
    .level          (s_tdata[0]),
    .debounce_ticks (debounce_ticks),
    .evt            (evt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= DEBOUNCE_RST;
      blink_period   <= BLINK_PER_RST;
      blink_on_ticks <= BLINK_ON_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE:  debounce_ticks <= cfg_data;
        REG_BLINK_PER: blink_period   <= cfg_data[PHASE_W-1:0];
        REG_BLINK_ON:  blink_on_ticks <= cfg_data[PHASE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    mode_is_chase_next = mode_is_chase;
    indicator_next     = indicator;
    led_base           = led_store;
    if (evt.change) begin
      if (evt.level) begin
        // press: toggle effect, clear LEDs, indicator low
        indicator_next     = 1'b0;
        mode_is_chase_next = !mode_is_chase;
        led_base           = '0;
      end else begin
        indicator_next     = 1'b1;
      end
    end

    period     = mode_is_chase_next ? CHASE_PERIOD : blink_period;
    phase_inc  = phase_count + 1'b1;
    phase_next = (phase_inc >= period) ? '0 : phase_inc;

    win      = chase_window(phase_next);
    win_prev = (win == 3'd0) ? 3'd5 : win - 3'd1;

    if (mode_is_chase_next) begin
      led_next = (led_base & ~(LED_N'(1) << win_prev)) | (LED_N'(1) << win);
    end else begin
      led_next = (phase_next < blink_on_ticks) ? ALL_LEDS : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_is_chase <= 1'b0;
      phase_count   <= '0;
      led_store     <= '0;
      indicator     <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (accept) begin
        mode_is_chase <= mode_is_chase_next;
        phase_count   <= phase_next;
        led_store     <= led_next;
        indicator     <= indicator_next;
        m_tvalid      <= 1'b1;
      end else if (m_tready) begin
        m_tvalid      <= 1'b0;
      end
    end
  end

  // result beat mirrors the state left by the last accepted tick
  assign m_tdata = {{(OUT_W - LED_N - 1 - MODE_W){1'b0}},
                    (mode_is_chase ? MODE_CHASE : MODE_BLINK),
                    indicator,
                    led_store};

endmodule
